FILE: hw/rtl/triangle_strip_fan_assembler_macros.svh
// Assertion macros for the triangle strip and fan assembler checker.
// Each macro expands to one labeled concurrent assertion on the clk edge.
`ifndef TRIANGLE_STRIP_FAN_ASSEMBLER_MACROS_SVH
`define TRIANGLE_STRIP_FAN_ASSEMBLER_MACROS_SVH

// Assertion that is switched off while reset is held.
`define TSFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also watches the reset cycles themselves.
`define TSFA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tsfa_pkg.sv
// Package for the triangle strip and fan assembler.
// Holds the word types, mode and register codes and sizing constants; no dependencies.
`default_nettype none

package tsfa_pkg;

  localparam int INDEX_BITS_DEFAULT = 32;
  localparam int FIELD_BITS         = 32;
  localparam int COUNT_BITS         = 16;
  localparam int MODE_BITS          = 2;
  localparam int CFG_INDEX_BITS     = 1;
  localparam int CFG_DATA_BITS      = 16;

  localparam logic [COUNT_BITS-1:0] VPP_RESET = 16'd3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LIST  = 2'd0,
    MODE_FAN   = 2'd1,
    MODE_STRIP = 2'd2
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PRIMITIVE_MODE         = 1'd0,
    REG_VERTICES_PER_PRIMITIVE = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] vertex_index;
    logic                  end_of_draw;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] corner_a;
    logic [FIELD_BITS-1:0] corner_b;
    logic [FIELD_BITS-1:0] corner_c;
    logic                  closes_primitive;
  } out_word_t;

  // Settings handed from the register file to the assembly core.
  typedef struct packed {
    logic [MODE_BITS-1:0]  primitive_mode;
    logic [COUNT_BITS-1:0] vertices_per_primitive;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/triangle_strip_fan_assembler.sv
// A triangle is registered into the result queue when the vertex word that completes it is taken.
// Throughput: one vertex word per cycle; the two-entry result queue keeps input flowing
//   while one triangle waits, and input stalls only when both queue entries are occupied.
// Reset (synchronous, active low) clears the mode to list, the primitive size to three,
//   the vertex history and position counter to zero, and empties the result queue.
`default_nettype none

module triangle_strip_fan_assembler #(
  parameter int INDEX_BITS = tsfa_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire tsfa_pkg::in_word_t                   in_word,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output tsfa_pkg::out_word_t                       out_word,
  input  wire logic                                 cfg_we,
  input  wire logic [tsfa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tsfa_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // Configuration registers. The user must write them only while the block is idle;
  // the block does not enforce this. The core uses them directly, without shadowing.
  logic [tsfa_pkg::MODE_BITS-1:0]  mode_r, mode_nxt;
  logic [tsfa_pkg::COUNT_BITS-1:0] vpp_r, vpp_nxt;
  tsfa_pkg::cfg_t                  cfg;

  logic                            accept;
  logic                            emit;
  logic                            queue_full;
  tsfa_pkg::out_word_t             tri_word;

  always_comb begin
    mode_nxt = mode_r;
    vpp_nxt  = vpp_r;
    if (cfg_we) begin
      case (cfg_index)
        tsfa_pkg::REG_PRIMITIVE_MODE: begin
          mode_nxt = cfg_data[tsfa_pkg::MODE_BITS-1:0];
        end
        tsfa_pkg::REG_VERTICES_PER_PRIMITIVE: begin
          vpp_nxt = cfg_data[tsfa_pkg::COUNT_BITS-1:0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tsfa_pkg::MODE_LIST;
      vpp_r  <= tsfa_pkg::VPP_RESET;
    end else begin
      mode_r <= mode_nxt;
      vpp_r  <= vpp_nxt;
    end
  end

  assign cfg.primitive_mode         = mode_r;
  assign cfg.vertices_per_primitive = vpp_r;

  // The stall depends only on queue occupancy, never on the output side this cycle.
  // Every accepted word can produce at most one triangle, so a free entry is enough.
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // The core turns each accepted vertex word into zero or one triangle and
  // updates its vertex history in the same cycle.
  tsfa_core #(
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .cfg      (cfg),
    .emit     (emit),
    .tri_word (tri_word)
  );

  // Triangles are registered into the queue, which drives the output channel.
  tsfa_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && emit),
    .push_word (tri_word),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tsfa_core.sv
// Assembly core: vertex history, position counter and triangle selection.
// Depends on tsfa_pkg for word types and mode codes.
`default_nettype none

module tsfa_core #(
  parameter int INDEX_BITS = tsfa_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire tsfa_pkg::in_word_t  in_word,
  input  wire tsfa_pkg::cfg_t      cfg,
  output logic                     emit,
  output tsfa_pkg::out_word_t      tri_word
);

  logic [INDEX_BITS-1:0]           anchor_r, anchor_nxt;
  logic [INDEX_BITS-1:0]           older_r, older_nxt;
  logic [INDEX_BITS-1:0]           newer_r, newer_nxt;
  logic [tsfa_pkg::COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]                      mod3_r, mod3_nxt;

  logic [INDEX_BITS-1:0]           vtx;
  logic [tsfa_pkg::COUNT_BITS-1:0] count;
  logic [tsfa_pkg::COUNT_BITS:0]   pos_inc;
  logic                            last;
  logic [INDEX_BITS-1:0]           ca, cb, cc;

  assign vtx     = in_word.vertex_index[INDEX_BITS-1:0];
  assign count   = (cfg.vertices_per_primitive == '0) ? tsfa_pkg::COUNT_BITS'(1)
                                                      : cfg.vertices_per_primitive;
  assign pos_inc = {1'b0, pos_r} + (tsfa_pkg::COUNT_BITS+1)'(1);
  assign last    = in_word.end_of_draw || (pos_inc >= {1'b0, count});

  // Triangle selection. Position modulo three is tracked in its own counter.
  always_comb begin
    emit = 1'b0;
    ca   = older_r;
    cb   = newer_r;
    cc   = vtx;
    case (cfg.primitive_mode)
      tsfa_pkg::MODE_LIST: begin
        emit = (mod3_r == 2'd2);
      end
      tsfa_pkg::MODE_FAN: begin
        emit = (pos_r >= tsfa_pkg::COUNT_BITS'(2));
        ca   = anchor_r;
      end
      tsfa_pkg::MODE_STRIP: begin
        emit = (pos_r >= tsfa_pkg::COUNT_BITS'(2));
        // Odd triangles swap the last two corners to keep the winding.
        if (pos_r[0]) begin
          cb = vtx;
          cc = newer_r;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    tri_word.corner_a         = tsfa_pkg::FIELD_BITS'(ca);
    tri_word.corner_b         = tsfa_pkg::FIELD_BITS'(cb);
    tri_word.corner_c         = tsfa_pkg::FIELD_BITS'(cc);
    tri_word.closes_primitive = last;
  end

  always_comb begin
    anchor_nxt = anchor_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    pos_nxt    = pos_r;
    mod3_nxt   = mod3_r;
    if (accept) begin
      if (pos_r == '0) begin
        anchor_nxt = vtx;
      end
      older_nxt = newer_r;
      newer_nxt = vtx;
      if (last) begin
        pos_nxt  = '0;
        mod3_nxt = 2'd0;
      end else begin
        pos_nxt  = pos_inc[tsfa_pkg::COUNT_BITS-1:0];
        mod3_nxt = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
      older_r  <= '0;
      newer_r  <= '0;
      pos_r    <= '0;
      mod3_r   <= 2'd0;
    end else begin
      anchor_r <= anchor_nxt;
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      pos_r    <= pos_nxt;
      mod3_r   <= mod3_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tsfa_out_queue.sv
// Two-entry result queue that decouples the assembly core from the output stall.
// Depends on tsfa_pkg for the result word type.
`default_nettype none

module tsfa_out_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tsfa_pkg::out_word_t  push_word,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tsfa_pkg::out_word_t       out_word
);

  localparam int DEPTH = 2;

  tsfa_pkg::out_word_t mem [DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;
  logic                pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'(DEPTH));
  assign out_word  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tsfa_checker.sv
// Port-level checker for the triangle strip and fan assembler, bound to the top level.
// Depends on tsfa_pkg and the assertion macros header.
`default_nettype none
`include "triangle_strip_fan_assembler_macros.svh"

module tsfa_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire tsfa_pkg::out_word_t  out_word
);

  // Reset leaves no triangle pending.
  `TSFA_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")

  // A held triangle keeps its word until it is taken.
  `TSFA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled triangle changed")

  // Input only stalls when triangles are waiting at the output.
  `TSFA_ASSERT(a_stall_needs_backlog, in_stall |-> out_valid, "input stalled with empty output")

  // A rise of output valid is always caused by a vertex word taken the cycle before.
  `TSFA_ASSERT(a_no_invented, $rose(out_valid) |-> $past(in_valid && !in_stall), "triangle without input")

endmodule

bind triangle_strip_fan_assembler tsfa_checker u_tsfa_checker (.*);

`default_nettype wire
